// ===== rtl/wavhp_pkg.sv =====
// Shared types and constants for the WAV header parser.
// Holds the request and result payload structs, mode and status codes, and header tags.
// No dependencies.
package wavhp_pkg;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } wavhp_in_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [30:0] data_length;
    } wavhp_out_t;

    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_EOS     = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_TRUNCATED  = 4'd1;
    localparam logic [3:0] ST_NO_RIFF    = 4'd2;
    localparam logic [3:0] ST_NO_WAVE    = 4'd3;
    localparam logic [3:0] ST_NO_FMT     = 4'd4;
    localparam logic [3:0] ST_FMT_SHORT  = 4'd5;
    localparam logic [3:0] ST_NOT_PCM    = 4'd6;
    localparam logic [3:0] ST_NOT_MONO   = 4'd7;
    localparam logic [3:0] ST_RATE       = 4'd8;
    localparam logic [3:0] ST_NOT_16BIT  = 4'd9;
    localparam logic [3:0] ST_UNKNOWN    = 4'd10;
    localparam logic [3:0] ST_BAD_SIZE   = 4'd11;

    // Tags as they appear once four little-endian bytes are gathered.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] TAG_FACT = 32'h7463_6166;

    localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
    localparam logic [31:0] RATE_RESET   = 32'd8000;

endpackage

// ===== rtl/wav_header_parser.sv =====
// WAV header parser top level: input register feeding the parse stage.
// Depends on wavhp_pkg, wavhp_in_reg and wavhp_core.
//
// The block takes one request per clock: a file byte, an end-of-stream mark or
// a restart. It checks the RIFF/WAVE header and gives one result per file,
// either the data chunk length with status ok or the first error found; later
// requests are dropped until a restart. Throughput is one request per cycle.
// Requests that make no result keep flowing while a result waits on out_ready;
// only a request that would make the next result waits until the held result
// is taken. An accepted request is held in the input register; the parse stage
// takes it from there and loads the result register, which drives out_valid.
// The expected sample rate resets to 8000 and is written through
// cfg_wr_en/cfg_wr_data.
module wav_header_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wavhp_pkg::wavhp_in_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wavhp_pkg::wavhp_out_t out_data
);

    logic                 s1_valid;
    logic                 s1_ready;
    wavhp_pkg::wavhp_in_t s1_data;

    wavhp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_data  (s1_data)
    );

    wavhp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s1_valid    (s1_valid),
        .s1_ready    (s1_ready),
        .s1_data     (s1_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// ===== rtl/wavhp_in_reg.sv =====
// Input register of the WAV header parser.
// Holds one accepted request until the parse stage takes it; uses wavhp_pkg.
module wavhp_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  wavhp_pkg::wavhp_in_t in_data,
    output logic              s1_valid,
    input  logic              s1_ready,
    output wavhp_pkg::wavhp_in_t s1_data
);

    logic                 valid_reg;
    logic                 valid_next;
    wavhp_pkg::wavhp_in_t data_reg;

    assign in_ready = !valid_reg || s1_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (s1_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule

// ===== rtl/wavhp_core.sv =====
// Parse stage of the WAV header parser: header state, field gathering,
// checks and the result register. Uses wavhp_pkg.
module wavhp_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    input  logic                  s1_valid,
    output logic                  s1_ready,
    input  wavhp_pkg::wavhp_in_t  s1_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wavhp_pkg::wavhp_out_t out_data
);

    localparam logic [4:0] PH_TYPE     = 5'd0;
    localparam logic [4:0] PH_RSIZE    = 5'd1;
    localparam logic [4:0] PH_FORM     = 5'd2;
    localparam logic [4:0] PH_FMT      = 5'd3;
    localparam logic [4:0] PH_HSIZE    = 5'd4;
    localparam logic [4:0] PH_FORMAT   = 5'd5;
    localparam logic [4:0] PH_CHANS    = 5'd6;
    localparam logic [4:0] PH_FREQ     = 5'd7;
    localparam logic [4:0] PH_BYSEC    = 5'd8;
    localparam logic [4:0] PH_BYSAM    = 5'd9;
    localparam logic [4:0] PH_BISAM    = 5'd10;
    localparam logic [4:0] PH_FMTSKIP  = 5'd11;
    localparam logic [4:0] PH_CTAG     = 5'd12;
    localparam logic [4:0] PH_CSIZE    = 5'd13;
    localparam logic [4:0] PH_FACTSKIP = 5'd14;

    logic [31:0] rate_reg;
    logic [4:0]  phase_reg,    phase_next;
    logic [1:0]  bif_reg,      bif_next;
    logic [31:0] shift_reg,    shift_next;
    logic [31:0] tag_reg,      tag_next;
    logic [31:0] skip_reg,     skip_next;
    logic        finished_reg, finished_next;
    logic        out_valid_reg, out_valid_next;
    wavhp_pkg::wavhp_out_t out_data_reg;

    logic        take;
    logic        emit;
    logic [3:0]  emit_status;
    logic [30:0] emit_len;
    logic [31:0] gathered;
    logic [2:0]  count_inc;
    logic        short_field;
    logic [31:0] skip_dec;

    assign s1_ready = take;

    always_comb
    begin
        phase_next    = phase_reg;
        bif_next      = bif_reg;
        shift_next    = shift_reg;
        tag_next      = tag_reg;
        skip_next     = skip_reg;
        finished_next = finished_reg;
        emit          = 1'b0;
        emit_status   = wavhp_pkg::ST_OK;
        emit_len      = '0;
        gathered      = shift_reg | (32'(s1_data.data_byte) << {bif_reg, 3'b000});
        count_inc     = {1'b0, bif_reg} + 3'd1;
        short_field   = phase_reg inside {PH_FORMAT, PH_CHANS, PH_BYSAM, PH_BISAM};
        skip_dec      = (skip_reg != '0) ? (skip_reg - 32'd1) : '0;

        if (s1_valid)
        begin
            if (s1_data.mode == wavhp_pkg::MODE_RESTART)
            begin
                phase_next    = PH_TYPE;
                bif_next      = '0;
                shift_next    = '0;
                tag_next      = '0;
                skip_next     = '0;
                finished_next = 1'b0;
            end
            else if (finished_reg)
            begin
                // After the result, everything but a restart is dropped.
            end
            else if (s1_data.mode == wavhp_pkg::MODE_EOS)
            begin
                emit        = 1'b1;
                emit_status = wavhp_pkg::ST_TRUNCATED;
            end
            else if (s1_data.mode == wavhp_pkg::MODE_BYTE)
            begin
                if (phase_reg == PH_FMTSKIP || phase_reg == PH_FACTSKIP)
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                    begin
                        phase_next = PH_CTAG;
                    end
                end
                else if (count_inc < (short_field ? 3'd2 : 3'd4))
                begin
                    bif_next   = count_inc[1:0];
                    shift_next = gathered;
                end
                else
                begin
                    bif_next   = '0;
                    shift_next = '0;
                    unique case (phase_reg)
                        PH_TYPE:
                        begin
                            tag_next   = gathered;
                            phase_next = PH_RSIZE;
                        end
                        PH_RSIZE:
                        begin
                            phase_next = PH_FORM;
                        end
                        PH_FORM:
                        begin
                            if (tag_reg != wavhp_pkg::TAG_RIFF)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NO_RIFF;
                            end
                            else if (gathered != wavhp_pkg::TAG_WAVE)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NO_WAVE;
                            end
                            else
                            begin
                                phase_next = PH_FMT;
                            end
                        end
                        PH_FMT:
                        begin
                            if (gathered != wavhp_pkg::TAG_FMT)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NO_FMT;
                            end
                            else
                            begin
                                phase_next = PH_HSIZE;
                            end
                        end
                        PH_HSIZE:
                        begin
                            if (gathered[31])
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_BAD_SIZE;
                            end
                            else if (gathered < wavhp_pkg::FMT_MIN_SIZE)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_FMT_SHORT;
                            end
                            else
                            begin
                                skip_next  = gathered - wavhp_pkg::FMT_MIN_SIZE;
                                phase_next = PH_FORMAT;
                            end
                        end
                        PH_FORMAT:
                        begin
                            if (gathered[15:0] != 16'd1)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NOT_PCM;
                            end
                            else
                            begin
                                phase_next = PH_CHANS;
                            end
                        end
                        PH_CHANS:
                        begin
                            if (gathered[15:0] != 16'd1)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NOT_MONO;
                            end
                            else
                            begin
                                phase_next = PH_FREQ;
                            end
                        end
                        PH_FREQ:
                        begin
                            if (gathered != rate_reg)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_RATE;
                            end
                            else
                            begin
                                phase_next = PH_BYSEC;
                            end
                        end
                        PH_BYSEC:
                        begin
                            phase_next = PH_BYSAM;
                        end
                        PH_BYSAM:
                        begin
                            if (gathered[15:0] != 16'd2)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_NOT_16BIT;
                            end
                            else
                            begin
                                phase_next = PH_BISAM;
                            end
                        end
                        PH_BISAM:
                        begin
                            phase_next = (skip_reg == '0) ? PH_CTAG : PH_FMTSKIP;
                        end
                        PH_CTAG:
                        begin
                            tag_next   = gathered;
                            phase_next = PH_CSIZE;
                        end
                        PH_CSIZE:
                        begin
                            if (tag_reg == wavhp_pkg::TAG_DATA)
                            begin
                                emit        = 1'b1;
                                if (gathered[31])
                                begin
                                    emit_status = wavhp_pkg::ST_BAD_SIZE;
                                end
                                else
                                begin
                                    emit_status = wavhp_pkg::ST_OK;
                                    emit_len    = gathered[30:0];
                                end
                            end
                            else if (tag_reg != wavhp_pkg::TAG_FACT)
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_UNKNOWN;
                            end
                            else if (gathered[31])
                            begin
                                emit        = 1'b1;
                                emit_status = wavhp_pkg::ST_BAD_SIZE;
                            end
                            else
                            begin
                                skip_next  = gathered;
                                phase_next = (gathered == '0) ? PH_CTAG : PH_FACTSKIP;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_TYPE;
                        end
                    endcase
                end
            end
        end

        // Only a request that makes a result has to wait for room in the result
        // register; every other request passes while an earlier result is held.
        take = s1_valid && (!emit || !out_valid_reg || out_ready);
        if (!take)
        begin
            phase_next    = phase_reg;
            bif_next      = bif_reg;
            shift_next    = shift_reg;
            tag_next      = tag_reg;
            skip_next     = skip_reg;
            finished_next = finished_reg;
            emit          = 1'b0;
        end

        if (emit)
        begin
            finished_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= wavhp_pkg::RATE_RESET;
            phase_reg     <= PH_TYPE;
            bif_reg       <= '0;
            shift_reg     <= '0;
            tag_reg       <= '0;
            skip_reg      <= '0;
            finished_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rate_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            bif_reg       <= bif_next;
            shift_reg     <= shift_next;
            tag_reg       <= tag_next;
            skip_reg      <= skip_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg.status      <= emit_status;
            out_data_reg.data_length <= emit_len;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
